[hw/rtl/weighted_quorum_vote_tally_defines.svh]
// Assertion macros shared by the weighted quorum vote tally RTL.
`ifndef WEIGHTED_QUORUM_VOTE_TALLY_DEFINES_SVH
`define WEIGHTED_QUORUM_VOTE_TALLY_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define WQVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define WQVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wqvt_pkg.sv]
// Package: codes, widths and defaults for the weighted quorum vote tally.
`timescale 1ns / 1ps
package wqvt_pkg;

  localparam int VOTER_IDX_W  = 6;
  localparam int VOTER_SPAN   = 1 << VOTER_IDX_W;
  localparam int WEIGHT_W     = 32;
  localparam int TOTAL_W      = 64;
  localparam int RESULT_W     = 2;
  localparam int PHASE_W      = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int NUM_VOTERS_DEF = 64;

  localparam logic [PHASE_W-1:0] PH_UNRESTRICTED  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RESTRICTED    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WEAK_ACHIEVED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WEAK_FINAL    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STRONG        = 3'd4;

  localparam logic [RESULT_W-1:0] RES_SUCCESS   = 2'd0;
  localparam logic [RESULT_W-1:0] RES_DUPLICATE = 2'd1;
  localparam logic [RESULT_W-1:0] RES_BAD_SIG   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_QUORUM     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_LIMIT = 1'd1;

endpackage

[hw/rtl/wqvt_in_if.sv]
// Interface: vote input channel (valid/ready plus vote payload).
`timescale 1ns / 1ps
interface wqvt_in_if
  import wqvt_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   strong_vote;
  logic [VOTER_IDX_W-1:0] voter_index;
  logic [WEIGHT_W-1:0]    vote_weight;
  logic                   signature_ok;

  modport source (output valid, strong_vote, voter_index, vote_weight, signature_ok,
                  input ready);
  modport sink   (input valid, strong_vote, voter_index, vote_weight, signature_ok,
                  output ready);
endinterface

[hw/rtl/wqvt_out_if.sv]
// Interface: vote result channel (valid/ready plus result payload).
`timescale 1ns / 1ps
interface wqvt_out_if
  import wqvt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] vote_result;
  logic [PHASE_W-1:0]  cert_phase;
  logic                quorum_ok;

  modport source (output valid, vote_result, cert_phase, quorum_ok, input ready);
  modport sink   (input valid, vote_result, cert_phase, quorum_ok, output ready);
endinterface

[hw/rtl/weighted_quorum_vote_tally.sv]
// Weighted quorum vote tally: vote checking, weight totals and certificate phase.
// One vote per cycle, sustained while out_res.ready stays high. A vote transaction on
// in_vote lands in an input register; the bitmap test, the saturating weight add and
// the quorum/limit compares then run from that register against the current tally
// state, and the state plus the result register update together, so the next vote
// sees the new state with no bubble. A vote's result goes through the input register
// and the result register. The input register doubles as a skid stage: while a
// result waits on out_res.ready one more vote is still taken. The per-cycle path
// is one 64-bit three-operand add and compare against quorum_weight. Strong and
// weak voted bitmaps are flip-flops cleared at once by reset; only the first
// min(NUM_VOTERS, 64) voters have storage, any other index is rejected as a
// duplicate. Config writes (cfg_index 0: quorum_weight, 1: weak_weight_limit)
// are meant to happen while no vote is in flight.
`timescale 1ns / 1ps
`include "weighted_quorum_vote_tally_defines.svh"
module weighted_quorum_vote_tally
  import wqvt_pkg::*;
#(
  parameter int NUM_VOTERS = NUM_VOTERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wqvt_in_if.sink              in_vote,
  wqvt_out_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_wdata
);

  // Only indexes below NUM_VOTERS that the 6-bit field can reach get a mark bit.
  localparam int MARK_DEPTH = (NUM_VOTERS < VOTER_SPAN) ? NUM_VOTERS : VOTER_SPAN;

  // config
  logic [TOTAL_W-1:0] quorum_r;
  logic [TOTAL_W-1:0] weak_limit_r;

  // tally state
  logic [MARK_DEPTH-1:0] strong_marks_r, strong_marks_nxt;
  logic [MARK_DEPTH-1:0] weak_marks_r, weak_marks_nxt;
  logic [TOTAL_W-1:0]    strong_total_r, strong_total_nxt;
  logic [TOTAL_W-1:0]    weak_total_r, weak_total_nxt;
  logic [PHASE_W-1:0]    phase_r, phase_nxt;

  // input stage
  logic                   s1_valid_r;
  logic                   s1_strong_r;
  logic [VOTER_IDX_W-1:0] s1_idx_r;
  logic [WEIGHT_W-1:0]    s1_weight_r;
  logic                   s1_sig_r;

  // result stage
  logic                out_valid_r;
  logic [RESULT_W-1:0] out_result_r;
  logic [PHASE_W-1:0]  out_phase_r;
  logic                out_quorum_r;

  logic advance;   // result register free to load
  logic fire;      // vote in the input register gets processed this cycle
  logic in_fire;

  assign advance = !out_valid_r || out_res.ready;
  assign fire    = s1_valid_r && advance;
  assign in_vote.ready = !s1_valid_r || advance;
  assign in_fire = in_vote.valid && in_vote.ready;

  assign out_res.valid       = out_valid_r;
  assign out_res.vote_result = out_result_r;
  assign out_res.cert_phase  = out_phase_r;
  assign out_res.quorum_ok   = out_quorum_r;

  // ---- vote checks --------------------------------------------------------
  logic [MARK_DEPTH-1:0] sel;
  logic                  in_range;
  logic                  own_mark;
  logic [RESULT_W-1:0]   result;
  logic                  accepted;

  always_comb begin
    for (int i = 0; i < MARK_DEPTH; i++) begin
      sel[i] = (s1_idx_r == VOTER_IDX_W'(i));
    end
  end

  // An index with no mark bit selects nothing, which flags it out of range.
  assign in_range = |sel;
  assign own_mark = s1_strong_r ? |(strong_marks_r & sel) : |(weak_marks_r & sel);

  always_comb begin
    if (!in_range || own_mark) begin
      result = RES_DUPLICATE;
    end else if (!s1_sig_r) begin
      result = RES_BAD_SIG;
    end else begin
      result = RES_SUCCESS;
    end
  end

  assign accepted = (result == RES_SUCCESS);

  // ---- weight arithmetic --------------------------------------------------
  logic [TOTAL_W:0]   strong_add, weak_add;
  logic [TOTAL_W-1:0] strong_sat, weak_sat;
  logic [TOTAL_W+1:0] combo_sum;
  logic               strong_ge_q, combo_ge_q, weak_gt_lim, weak_ge_lim;

  assign strong_add = {1'b0, strong_total_r} + {(TOTAL_W-WEIGHT_W+1)'(0), s1_weight_r};
  assign weak_add   = {1'b0, weak_total_r} + {(TOTAL_W-WEIGHT_W+1)'(0), s1_weight_r};
  assign strong_sat = strong_add[TOTAL_W] ? '1 : strong_add[TOTAL_W-1:0];
  assign weak_sat   = weak_add[TOTAL_W] ? '1 : weak_add[TOTAL_W-1:0];

  // Exact three-way sum; against a 64-bit quorum this matches the saturated sum.
  assign combo_sum = {2'b00, strong_total_r} + {2'b00, weak_total_r}
                   + {(TOTAL_W-WEIGHT_W+2)'(0), s1_weight_r};
  assign combo_ge_q = (combo_sum >= {2'b00, quorum_r});

  assign strong_ge_q = (strong_sat >= quorum_r);
  assign weak_gt_lim = (weak_sat > weak_limit_r);
  assign weak_ge_lim = (weak_sat >= weak_limit_r);

  // ---- phase update -------------------------------------------------------
  logic [PHASE_W-1:0] weak_step;

  always_comb begin
    phase_nxt = phase_r;
    weak_step = combo_ge_q ? PH_WEAK_ACHIEVED : phase_r;
    if (accepted) begin
      if (s1_strong_r) begin
        case (phase_r)
          PH_UNRESTRICTED, PH_RESTRICTED: begin
            if (strong_ge_q) begin
              phase_nxt = PH_STRONG;
            end else if (combo_ge_q) begin
              phase_nxt = (phase_r == PH_RESTRICTED) ? PH_WEAK_FINAL : PH_WEAK_ACHIEVED;
            end
          end
          PH_WEAK_ACHIEVED: begin
            if (strong_ge_q) begin
              phase_nxt = PH_STRONG;
            end
          end
          default: begin
            phase_nxt = phase_r;   // weak-final and strong hold
          end
        endcase
      end else begin
        case (phase_r)
          PH_UNRESTRICTED, PH_RESTRICTED: begin
            phase_nxt = weak_step;
            if (weak_gt_lim) begin
              if (weak_step == PH_WEAK_ACHIEVED) begin
                phase_nxt = PH_WEAK_FINAL;
              end else if (weak_step == PH_UNRESTRICTED) begin
                phase_nxt = PH_RESTRICTED;
              end
            end
          end
          PH_WEAK_ACHIEVED: begin
            if (weak_ge_lim) begin
              phase_nxt = PH_WEAK_FINAL;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // ---- next tally state ---------------------------------------------------
  always_comb begin
    strong_marks_nxt = strong_marks_r;
    weak_marks_nxt   = weak_marks_r;
    strong_total_nxt = strong_total_r;
    weak_total_nxt   = weak_total_r;
    if (accepted) begin
      if (s1_strong_r) begin
        strong_marks_nxt = strong_marks_r | sel;
        strong_total_nxt = strong_sat;
      end else begin
        weak_marks_nxt = weak_marks_r | sel;
        weak_total_nxt = weak_sat;
      end
    end
  end

  // ---- registers ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quorum_r     <= '0;
      weak_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUORUM:     quorum_r     <= cfg_wdata;
        REG_WEAK_LIMIT: weak_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strong_marks_r <= '0;
      weak_marks_r   <= '0;
      strong_total_r <= '0;
      weak_total_r   <= '0;
      phase_r        <= PH_UNRESTRICTED;
    end else if (fire) begin
      strong_marks_r <= strong_marks_nxt;
      weak_marks_r   <= weak_marks_nxt;
      strong_total_r <= strong_total_nxt;
      weak_total_r   <= weak_total_nxt;
      phase_r        <= phase_nxt;
    end
  end

  // input register: loads on every input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_vote.ready) begin
      s1_valid_r <= in_vote.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_strong_r <= in_vote.strong_vote;
      s1_idx_r    <= in_vote.voter_index;
      s1_weight_r <= in_vote.vote_weight;
      s1_sig_r    <= in_vote.signature_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result_r <= result;
      out_phase_r  <= phase_nxt;
      out_quorum_r <= (phase_nxt == PH_WEAK_ACHIEVED) || (phase_nxt == PH_WEAK_FINAL)
                   || (phase_nxt == PH_STRONG);
    end
  end

  // ---- assertions ---------------------------------------------------------
  logic [2*TOTAL_W+PHASE_W-1:0] tally_snap;

  assign tally_snap = {strong_total_r, weak_total_r, phase_r};

  `WQVT_ASSERT_NEXT(a_strong_holds, phase_r == PH_STRONG, phase_r == PH_STRONG, "strong left")
  `WQVT_ASSERT_NEXT(a_wf_hold, phase_r == PH_WEAK_FINAL, phase_r == PH_WEAK_FINAL, "final left")
  `WQVT_ASSERT_NEXT(a_reject_hold, fire && !accepted, $stable(tally_snap), "reject moved tally")
  `WQVT_ASSERT_NEXT(a_out_phase, fire, out_valid_r && out_phase_r == phase_r, "result phase off")

endmodule

[verif/weighted_quorum_vote_tally_tb.sv]
// Testbench for the weighted quorum vote tally: directed table plus steered random votes.
`timescale 1ns / 1ps
module weighted_quorum_vote_tally_tb;
  import wqvt_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 6;
  localparam int VOTES_PER_SEGMENT = 135;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 8;
  // Watchdog limit in ns; meant to lie well beyond the slowest legal run.
  localparam longint RUN_LIMIT_NS = 2_000_000;
  localparam logic [TOTAL_W-1:0] ALL_ONES = '1;

  // One vote as it travels on in_vote.
  typedef struct packed {
    logic                   strong_vote;
    logic [VOTER_IDX_W-1:0] voter;
    logic [WEIGHT_W-1:0]    weight;
    logic                   sig_ok;
  } ballot_t;

  // One result as it travels on out_res.
  typedef struct packed {
    logic [RESULT_W-1:0] status;
    logic [PHASE_W-1:0]  phase;
    logic                met;
  } verdict_t;

  // A row of the directed table: either a register write or a vote.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [TOTAL_W-1:0]   reg_val;
    ballot_t              ballot;
    bit                   typed;
    verdict_t             want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TOTAL_W-1:0]   cfg_wdata;

  wqvt_in_if  in_vote ();
  wqvt_out_if out_res ();

  weighted_quorum_vote_tally uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vote   (in_vote),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tally mirror: voted bitmaps, weight totals, certificate phase and the two
  // registers, updated on every accepted vote transaction.
  // ---------------------------------------------------------------------------
  logic [VOTER_SPAN-1:0] strong_seen;
  logic [VOTER_SPAN-1:0] weak_seen;
  logic [TOTAL_W-1:0]    strong_acc;
  logic [TOTAL_W-1:0]    weak_acc;
  logic [PHASE_W-1:0]    cert_phase_q;
  logic [TOTAL_W-1:0]    quorum_reg;
  logic [TOTAL_W-1:0]    weak_limit_reg;

  verdict_t expected_verdicts[$];
  int       error_count = 0;
  int       mismatch_count = 0;
  int       burst_left = 0;
  bit       sender_gaps_on = 1'b1;

  // Totals clamp at all ones instead of wrapping.
  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? ALL_ONES : s[TOTAL_W-1:0];
  endfunction

  // Applies one vote to the mirror and returns the result the block must give.
  function automatic verdict_t tally_ballot(input ballot_t b);
    verdict_t           v;
    logic [TOTAL_W-1:0] w;
    bit                 dup;
    w   = {{(TOTAL_W - WEIGHT_W){1'b0}}, b.weight};
    dup = b.strong_vote ? strong_seen[b.voter] : weak_seen[b.voter];
    // Duplicate check wins over a bad signature; rejects leave state alone.
    if (dup) begin
      v.status = RES_DUPLICATE;
    end else if (!b.sig_ok) begin
      v.status = RES_BAD_SIG;
    end else begin
      v.status = RES_SUCCESS;
      if (b.strong_vote) begin
        strong_seen[b.voter] = 1'b1;
        strong_acc = sat_add(strong_acc, w);
        if (cert_phase_q == PH_UNRESTRICTED || cert_phase_q == PH_RESTRICTED) begin
          if (strong_acc >= quorum_reg) begin
            cert_phase_q = PH_STRONG;
          end else if (sat_add(weak_acc, strong_acc) >= quorum_reg) begin
            cert_phase_q = (cert_phase_q == PH_RESTRICTED) ? PH_WEAK_FINAL : PH_WEAK_ACHIEVED;
          end
        end else if (cert_phase_q == PH_WEAK_ACHIEVED && strong_acc >= quorum_reg) begin
          cert_phase_q = PH_STRONG;
        end
      end else begin
        weak_seen[b.voter] = 1'b1;
        weak_acc = sat_add(weak_acc, w);
        if (cert_phase_q == PH_UNRESTRICTED || cert_phase_q == PH_RESTRICTED) begin
          if (sat_add(weak_acc, strong_acc) >= quorum_reg) begin
            cert_phase_q = PH_WEAK_ACHIEVED;
          end
          // Strictly beyond the limit here, at-or-beyond once weak quorum is in.
          if (weak_acc > weak_limit_reg) begin
            if (cert_phase_q == PH_WEAK_ACHIEVED) begin
              cert_phase_q = PH_WEAK_FINAL;
            end else if (cert_phase_q == PH_UNRESTRICTED) begin
              cert_phase_q = PH_RESTRICTED;
            end
          end
        end else if (cert_phase_q == PH_WEAK_ACHIEVED && weak_acc >= weak_limit_reg) begin
          cert_phase_q = PH_WEAK_FINAL;
        end
      end
    end
    v.phase = cert_phase_q;
    v.met = (cert_phase_q == PH_WEAK_ACHIEVED || cert_phase_q == PH_WEAK_FINAL ||
             cert_phase_q == PH_STRONG);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers. Typed rows all run with the phase held at
  // unrestricted, so only the status has to be spelled out.
  // ---------------------------------------------------------------------------
  function automatic plan_row_t vote_row(input bit s, input logic [VOTER_IDX_W-1:0] idx,
                                         input logic [WEIGHT_W-1:0] w, input bit sig,
                                         input bit typed, input logic [RESULT_W-1:0] status);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = REG_QUORUM;
    r.reg_val = '0;
    r.ballot = '{strong_vote: s, voter: idx, weight: w, sig_ok: sig};
    r.typed = typed;
    r.want = '{status: status, phase: PH_UNRESTRICTED, met: 1'b0};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [TOTAL_W-1:0] val);
    plan_row_t r;
    r = vote_row(1'b0, '0, '0, 1'b0, 1'b0, RES_SUCCESS);
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random votes. About a quarter are well-formed: a voter that has not yet
  // voted in this kind, nearly always with a good signature. The rest hit
  // random voters and random signatures, so duplicates dominate once the
  // bitmaps fill. Weights lean on zero, all ones and small values.
  // ---------------------------------------------------------------------------
  function automatic ballot_t random_ballot();
    ballot_t                b;
    int                     start;
    logic [VOTER_IDX_W-1:0] idx;
    b.strong_vote = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 25) begin
      start = $urandom_range(0, VOTER_SPAN - 1);
      b.voter = VOTER_IDX_W'(start);
      for (int k = 0; k < VOTER_SPAN; k++) begin
        idx = VOTER_IDX_W'(start + k);
        if (!(b.strong_vote ? strong_seen[idx] : weak_seen[idx])) begin
          b.voter = idx;
          break;
        end
      end
      b.sig_ok = ($urandom_range(0, 9) != 0);
    end else begin
      b.voter = VOTER_IDX_W'($urandom);
      b.sig_ok = 1'($urandom_range(0, 1));
    end
    case ($urandom_range(0, 9))
      0:       b.weight = '0;
      1, 2:    b.weight = '1;
      3, 4, 5: b.weight = WEIGHT_W'($urandom_range(0, 1000));
      default: b.weight = $urandom;
    endcase
    return b;
  endfunction

  // Sender pacing: bursts of random length, random gaps between them.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_vote.valid <= 1'b0;
      end
    end
    burst_left--;
  endtask

  // Drives one vote and waits for its transaction. The expectation is queued
  // at the accepting edge; typed rows override the mirror's answer.
  task automatic send_vote(input ballot_t b, input bit typed, input verdict_t want);
    verdict_t mirrored;
    @(negedge clk);
    in_vote.valid        <= 1'b1;
    in_vote.strong_vote  <= b.strong_vote;
    in_vote.voter_index  <= b.voter;
    in_vote.vote_weight  <= b.weight;
    in_vote.signature_ok <= b.sig_ok;
    do @(posedge clk); while (in_vote.ready !== 1'b1);
    mirrored = tally_ballot(b);
    expected_verdicts.push_back(typed ? want : mirrored);
  endtask

  // Register writes only with nothing in flight: every vote gives exactly one
  // result, so an empty expectation queue means the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOTAL_W-1:0] val);
    @(negedge clk);
    in_vote.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_QUORUM:     quorum_reg = val;
      REG_WEAK_LIMIT: weak_limit_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready follows its own open/stall pattern, with an occasional
  // long open stretch. Results are sampled at the rising edge and checked at
  // the next falling edge, after the sender has queued anything accepted on
  // that same edge.
  // ---------------------------------------------------------------------------
  initial begin
    int open_len;
    int stall_len;
    out_res.ready = 1'b0;
    forever begin
      open_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      stall_len = $urandom_range(0, 5);
      repeat (open_len) begin
        @(negedge clk);
        out_res.ready <= 1'b1;
      end
      repeat (stall_len) begin
        @(negedge clk);
        out_res.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t seen;
    verdict_t want;
    if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      seen = '{status: out_res.vote_result, phase: out_res.cert_phase,
               met: out_res.quorum_ok};
      @(negedge clk);
      if (expected_verdicts.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result transaction with nothing expected: status=%0d phase=%0d met=%0b",
                   $realtime, seen.status, seen.phase, seen.met);
      end else begin
        want = expected_verdicts.pop_front();
        if (seen.status !== want.status || seen.phase !== want.phase ||
            seen.met !== want.met) begin
          error_count++;
          mismatch_count++;
          // fields are status/phase/met
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     $realtime, want.status, want.phase, want.met,
                     seen.status, seen.phase, seen.met);
        end
      end
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t          plan[$];
    ballot_t            b;
    logic [TOTAL_W-1:0] margin;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] quorum_next;
    logic [TOTAL_W-1:0] limit_next;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_QUORUM;
    cfg_wdata            = '0;
    in_vote.valid        = 1'b0;
    in_vote.strong_vote  = 1'b0;
    in_vote.voter_index  = '0;
    in_vote.vote_weight  = '0;
    in_vote.signature_ok = 1'b0;

    strong_seen    = '0;
    weak_seen      = '0;
    strong_acc     = '0;
    weak_acc       = '0;
    cert_phase_q   = PH_UNRESTRICTED;
    quorum_reg     = '0;
    weak_limit_reg = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Both registers at all ones pin the phase at unrestricted,
    // so every status can be read straight off the voting history.
    plan.push_back(cfg_row(REG_QUORUM, ALL_ONES));
    plan.push_back(cfg_row(REG_WEAK_LIMIT, ALL_ONES));
    plan.push_back(vote_row(1'b1, 6'd0, 32'h0, 1'b1, 1'b1, RES_SUCCESS));
    plan.push_back(vote_row(1'b1, 6'd0, 32'd5, 1'b1, 1'b1, RES_DUPLICATE));
    // duplicate is reported ahead of a bad signature
    plan.push_back(vote_row(1'b1, 6'd0, 32'd5, 1'b0, 1'b1, RES_DUPLICATE));
    // same voter, other kind: accepted
    plan.push_back(vote_row(1'b0, 6'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, RES_SUCCESS));
    plan.push_back(vote_row(1'b0, 6'd0, 32'd1, 1'b1, 1'b1, RES_DUPLICATE));
    plan.push_back(vote_row(1'b1, 6'd63, 32'hFFFF_FFFF, 1'b0, 1'b1, RES_BAD_SIG));
    // a rejected signature must not have marked the voter
    plan.push_back(vote_row(1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b1, RES_SUCCESS));
    plan.push_back(vote_row(1'b0, 6'd63, 32'h0, 1'b0, 1'b1, RES_BAD_SIG));
    plan.push_back(vote_row(1'b0, 6'd42, 32'hAAAA_AAAA, 1'b1, 1'b1, RES_SUCCESS));
    plan.push_back(vote_row(1'b1, 6'd21, 32'h5555_5555, 1'b1, 1'b0, RES_SUCCESS));
    // weak total now sits exactly on the limit: not beyond, stays unrestricted
    plan.push_back(cfg_row(REG_WEAK_LIMIT, 64'h1_AAAA_AAA9));
    plan.push_back(vote_row(1'b0, 6'd1, 32'h0, 1'b1, 1'b1, RES_SUCCESS));
    plan.push_back(vote_row(1'b1, 6'd42, 32'd1, 1'b1, 1'b0, RES_SUCCESS));
    plan.push_back(vote_row(1'b0, 6'd42, 32'd7, 1'b0, 1'b1, RES_DUPLICATE));
    plan.push_back(vote_row(1'b0, 6'd21, 32'h0, 1'b0, 1'b1, RES_BAD_SIG));
    plan.push_back(vote_row(1'b1, 6'd21, 32'h0, 1'b0, 1'b1, RES_DUPLICATE));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        pace();
        send_vote(plan[i].ballot, plan[i].typed, plan[i].want);
      end
    end

    // Random part in four segments. The phase never falls back, so each
    // segment sets the registers relative to the current totals to push the
    // phase one step further: limit first, then a reachable quorum, then a
    // zero limit, and finally a zero quorum that ends in a terminal phase.
    for (int seg = 1; seg <= 4; seg++) begin
      margin = {29'b0, 3'($urandom_range(0, 7)), 32'($urandom)};
      total  = sat_add(strong_acc, weak_acc);
      case (seg)
        1:       quorum_next = ALL_ONES;
        2, 3:    quorum_next = sat_add(total, margin);
        default: quorum_next = '0;
      endcase
      case (seg)
        3: limit_next = '0;
        4: limit_next = sat_add(weak_acc, margin);
        default: begin
          case ($urandom_range(0, 2))
            0:       limit_next = weak_acc;
            1:       limit_next = sat_add(weak_acc, margin);
            default: limit_next = ALL_ONES;
          endcase
        end
      endcase
      write_reg(REG_QUORUM, quorum_next);
      write_reg(REG_WEAK_LIMIT, limit_next);

      // one segment runs back to back on the sender side
      sender_gaps_on = (seg != 2);
      repeat (VOTES_PER_SEGMENT) begin
        b = random_ballot();
        pace();
        send_vote(b, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_vote.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/wqvt_pkg.sv
hw/rtl/wqvt_in_if.sv
hw/rtl/wqvt_out_if.sv
hw/rtl/weighted_quorum_vote_tally.sv
verif/weighted_quorum_vote_tally_tb.sv
